### hdl/window_layer_zorder_stack_macros.svh
// Assertion macros for the layer stacking block.
// Each one checks a property on the rising edge of clk, off while rst is high.
`ifndef WINDOW_LAYER_ZORDER_STACK_MACROS_SVH
`define WINDOW_LAYER_ZORDER_STACK_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define WLZS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WLZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define WLZS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define WLZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/wlzs_pkg.sv
`timescale 1ns / 1ps

package wlzs_pkg;

   localparam int NUM_LAYERS_DEFAULT = 256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPLY
   } state_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_SET   = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_ALLOC = 2'd2
   } status_type;

   // Layer index width: wide enough for the slot count and for an 8-bit layer id.
   function automatic int idx_width(input int n);
      return (n > 256) ? $clog2(n) : 8;
   endfunction

   // Signed height width: -1 up to n-1.
   function automatic int ht_width(input int n);
      return $clog2(n) + 1;
   endfunction

   // valid, cmd, id, hit, in_use, height, slot
   function automatic int walk_width(input int n);
      return 4 + 2 * idx_width(n) + ht_width(n);
   endfunction

   // valid, id, height, lo, hi, up
   function automatic int bcast_width(input int n);
      return 4 + idx_width(n) + 3 * ht_width(n);
   endfunction

endpackage

### hdl/wlzs_cell.sv
`timescale 1ns / 1ps

module wlzs_cell
   import wlzs_pkg::*;
#(
   parameter int NUM_LAYERS = NUM_LAYERS_DEFAULT,
   parameter int CELL_INDEX = 0,
   localparam int WALK_W = walk_width(NUM_LAYERS),
   localparam int BCAST_W = bcast_width(NUM_LAYERS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [WALK_W-1:0]  walk_i,
   output logic [WALK_W-1:0]  walk_o,
   input  logic [BCAST_W-1:0] bcast_i
);

   localparam int IDX_W = idx_width(NUM_LAYERS);
   localparam int HT_W = ht_width(NUM_LAYERS);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
   localparam logic signed [HT_W-1:0] HIDDEN = '1;

   typedef struct packed {
      logic                   valid;
      command_type            cmd;
      logic [IDX_W-1:0]       id;
      logic                   hit;
      logic                   in_use;
      logic signed [HT_W-1:0] height;
      logic [IDX_W-1:0]       slot;
   } walk_type;

   typedef struct packed {
      logic                   valid;
      logic [IDX_W-1:0]       id;
      logic signed [HT_W-1:0] height;
      logic signed [HT_W:0]   lo;
      logic signed [HT_W:0]   hi;
      logic                   up;
   } bcast_type;

   walk_type               walk_up;
   walk_type               walk_in;
   walk_type               walk_ff;
   bcast_type              bcast;
   logic                   in_use_ff;
   logic                   in_use_in;
   logic signed [HT_W-1:0] height_ff;
   logic signed [HT_W-1:0] height_in;
   logic signed [HT_W:0]   height_x;

   assign walk_up = walk_i;
   assign bcast   = bcast_i;
   assign walk_o  = walk_ff;

   always_comb begin
      walk_in   = walk_up;
      in_use_in = in_use_ff;
      height_in = height_ff;
      height_x  = (HT_W + 1)'(height_ff);

      if (walk_up.valid) begin
         unique case (walk_up.cmd)
            CMD_ALLOC: begin
               // first free cell on the way claims itself
               if (!walk_up.hit && !in_use_ff) begin
                  walk_in.hit  = 1'b1;
                  walk_in.slot = MY_IDX;
                  in_use_in    = 1'b1;
                  height_in    = HIDDEN;
               end
            end
            CMD_SET: begin
               if (walk_up.id == MY_IDX) begin
                  walk_in.hit    = 1'b1;
                  walk_in.in_use = in_use_ff;
                  walk_in.height = height_ff;
               end
            end
            default: walk_in = walk_up;
         endcase
      end

      if (bcast.valid && in_use_ff) begin
         if (bcast.id == MY_IDX) begin
            height_in = bcast.height;
         end else if ($signed(height_x) >= $signed(bcast.lo) &&
                      $signed(height_x) <= $signed(bcast.hi)) begin
            height_in = bcast.up ? height_ff + HT_W'(1) : height_ff - HT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= '0;
         in_use_ff <= 1'b0;
         height_ff <= HIDDEN;
      end else begin
         walk_ff   <= walk_in;
         in_use_ff <= in_use_in;
         height_ff <= height_in;
      end
   end

endmodule

### hdl/window_layer_zorder_stack.sv
// Layer stacking order. One cell per layer slot holds whether the slot is in use
// and its stacking height (-1 hidden). A command is taken when start is high and
// busy is low; a word then walks the row of NUM_LAYERS cells, one cell per clock.
// On the way an allocate claims the lowest free cell, and a set-height picks up
// the addressed layer's current height. At the end of the row the controller
// clamps the height, settles the new top and, when the height changed, sends one
// broadcast that renumbers the layers lying between the old and new height, or,
// for a hide or a hidden layer put into the stack, from there up to the top. The
// result word is registered from the word at the end of the row and marked by
// rsp_strobe for exactly one cycle; the receiver cannot stall it, so capture it
// then. busy stays high until the broadcast has been applied, so no new command
// is taken before the last one is through. Only allocated layers take part in the stack.
`timescale 1ns / 1ps
`include "window_layer_zorder_stack_macros.svh"

module window_layer_zorder_stack
   import wlzs_pkg::*;
#(
   parameter int NUM_LAYERS = NUM_LAYERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [7:0]        req_layer_id,
   input  logic signed [9:0] req_height,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_result_layer,
   output logic signed [8:0] rsp_new_height,
   output logic signed [8:0] rsp_top_height,
   output logic              rsp_redraw
);

   localparam int IDX_W = idx_width(NUM_LAYERS);
   localparam int HT_W = ht_width(NUM_LAYERS);
   localparam int WALK_W = walk_width(NUM_LAYERS);
   // clamp arithmetic: wide enough for the request and for top + 1
   localparam int CW = ((HT_W > 10) ? HT_W : 10) + 1;
   localparam logic signed [HT_W-1:0] HIDDEN = '1;
   localparam logic signed [CW-1:0] CW_HIDDEN = '1;
   localparam logic signed [8:0] RSP_HIDDEN = '1;

   typedef struct packed {
      logic                   valid;
      command_type            cmd;
      logic [IDX_W-1:0]       id;
      logic                   hit;
      logic                   in_use;
      logic signed [HT_W-1:0] height;
      logic [IDX_W-1:0]       slot;
   } walk_type;

   typedef struct packed {
      logic                   valid;
      logic [IDX_W-1:0]       id;
      logic signed [HT_W-1:0] height;
      logic signed [HT_W:0]   lo;
      logic signed [HT_W:0]   hi;
      logic                   up;
   } bcast_type;

   state_type              state_ff;
   state_type              state_in;
   logic signed [HT_W-1:0] top_ff;
   logic signed [HT_W-1:0] top_in;
   logic signed [9:0]      req_height_ff;
   logic signed [9:0]      req_height_in;
   bcast_type              bcast_ff;
   bcast_type              bcast_in;
   status_type             rsp_status_ff;
   status_type             rsp_status_in;
   logic [7:0]             rsp_layer_ff;
   logic [7:0]             rsp_layer_in;
   logic signed [8:0]      rsp_height_ff;
   logic signed [8:0]      rsp_height_in;
   logic signed [8:0]      rsp_top_ff;
   logic signed [8:0]      rsp_top_in;
   logic                   rsp_redraw_ff;
   logic                   rsp_redraw_in;

   walk_type               head;
   walk_type               tail;
   logic [WALK_W-1:0]      link [NUM_LAYERS+1];

   // end-of-row datapath
   logic signed [CW-1:0]   ceil_w;
   logic signed [CW-1:0]   req_w;
   logic signed [CW-1:0]   clamp_w;
   logic signed [HT_W-1:0] h_new;
   logic signed [HT_W:0]   old_x;
   logic signed [HT_W:0]   new_x;
   logic signed [HT_W:0]   top_x;
   logic signed [HT_W-1:0] top_next;
   logic                   set_ok;
   logic                   moved;
   bcast_type              bc;

   // ---------------------------------------------------------------------------
   // Cell row: word enters at link[0] and leaves at link[NUM_LAYERS]
   // ---------------------------------------------------------------------------
   assign link[0] = head;
   assign tail    = link[NUM_LAYERS];

   for (genvar i = 0; i < NUM_LAYERS; i++) begin : g_cell
      wlzs_cell #(
         .NUM_LAYERS (NUM_LAYERS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .walk_i  (link[i]),
         .walk_o  (link[i+1]),
         .bcast_i (bcast_ff)
      );
   end

   // ---------------------------------------------------------------------------
   // Clamp and renumbering range, from the word at the end of the row
   // ---------------------------------------------------------------------------
   always_comb begin
      old_x  = (HT_W + 1)'(tail.height);
      top_x  = (HT_W + 1)'(top_ff);
      set_ok = (tail.cmd == CMD_SET) && tail.hit && tail.in_use;

      // a visible layer cannot rise above the top; a hidden one may land on top+1
      ceil_w = tail.height[HT_W-1] ? CW'(top_ff) + CW'(1) : CW'(top_ff);
      req_w  = CW'(req_height_ff);

      clamp_w = req_w;
      if ($signed(clamp_w) > $signed(ceil_w)) begin
         clamp_w = ceil_w;
      end
      if ($signed(clamp_w) < $signed(CW_HIDDEN)) begin
         clamp_w = CW_HIDDEN;
      end
      h_new = HT_W'(clamp_w);
      new_x = (HT_W + 1)'(h_new);
      moved = set_ok && (h_new != tail.height);

      bc        = '0;
      bc.valid  = moved;
      bc.id     = tail.id;
      bc.height = h_new;
      bc.lo     = new_x;
      bc.hi     = old_x;
      top_next  = top_ff;

      if ($signed(old_x) > $signed(new_x)) begin
         if (!h_new[HT_W-1]) begin
            // lower within the stack: layers in between move up one place
            bc.lo = new_x;
            bc.hi = old_x - (HT_W + 1)'(1);
            bc.up = 1'b1;
         end else begin
            // hide: layers above close the gap
            bc.lo    = old_x + (HT_W + 1)'(1);
            bc.hi    = top_x;
            bc.up    = 1'b0;
            top_next = top_ff - HT_W'(1);
         end
      end else if ($signed(old_x) < $signed(new_x)) begin
         if (!tail.height[HT_W-1]) begin
            // raise within the stack: layers in between drop one place
            bc.lo = old_x + (HT_W + 1)'(1);
            bc.hi = new_x;
            bc.up = 1'b0;
         end else begin
            // insert a hidden layer: layers from there up make room
            bc.lo    = new_x;
            bc.hi    = top_x;
            bc.up    = 1'b1;
            top_next = top_ff + HT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Controller
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      req_height_in = req_height_ff;
      bcast_in      = '0;
      rsp_status_in = rsp_status_ff;
      rsp_layer_in  = rsp_layer_ff;
      rsp_height_in = rsp_height_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_redraw_in = rsp_redraw_ff;
      head          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               head.valid    = 1'b1;
               head.cmd      = command_type'(req_command);
               head.id       = IDX_W'(req_layer_id);
               req_height_in = req_height;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tail.valid) begin
               state_in      = ST_APPLY;
               rsp_height_in = RSP_HIDDEN;
               rsp_top_in    = 9'(top_ff);
               rsp_redraw_in = 1'b0;
               if (tail.cmd == CMD_ALLOC) begin
                  rsp_status_in = tail.hit ? STATUS_OK : STATUS_FULL;
                  rsp_layer_in  = tail.hit ? 8'(tail.slot) : 8'd0;
               end else if (!set_ok) begin
                  rsp_status_in = STATUS_NOT_ALLOC;
                  rsp_layer_in  = 8'(tail.id);
               end else begin
                  bcast_in      = bc;
                  top_in        = moved ? top_next : top_ff;
                  rsp_status_in = STATUS_OK;
                  rsp_layer_in  = 8'(tail.id);
                  rsp_height_in = 9'(h_new);
                  rsp_top_in    = 9'(moved ? top_next : top_ff);
                  rsp_redraw_in = moved;
               end
            end
         end
         ST_APPLY: begin
            // broadcast lands in the cells at the end of this cycle
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff   <= HIDDEN;
         bcast_ff <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         bcast_ff <= bcast_in;
      end
   end

   // hold the request height and the result word
   always_ff @(posedge clock) begin
      req_height_ff <= req_height_in;
      rsp_status_ff <= rsp_status_in;
      rsp_layer_ff  <= rsp_layer_in;
      rsp_height_ff <= rsp_height_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_redraw_ff <= rsp_redraw_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_APPLY);
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_layer = rsp_layer_ff;
   assign rsp_new_height   = rsp_height_ff;
   assign rsp_top_height   = rsp_top_ff;
   assign rsp_redraw       = rsp_redraw_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `WLZS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `WLZS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe, "accepted word did not raise busy")
   `WLZS_ASSERT_NEXT(a_top_hold, clock, reset, state_ff != ST_WALK, $stable(top_ff), "top changed outside end of walk")
   `WLZS_ASSERT_IMPL(a_tail_in_walk, clock, reset, tail.valid, state_ff == ST_WALK, "word left the cell row outside a walk")

endmodule

### dv/window_layer_zorder_stack_sb_pkg.sv
`timescale 1ns / 1ps

package window_layer_zorder_stack_sb_pkg;
   import wlzs_pkg::*;

   localparam int SLOTS = NUM_LAYERS_DEFAULT;

   typedef struct {
      status_type        status;
      logic [7:0]        layer;
      logic signed [8:0] new_height;
      logic signed [8:0] top_height;
      logic              redraw;
   } stack_reply_type;

   class layer_order_scoreboard;
      logic [7:0]      stack_pos [SLOTS];
      bit              in_use [SLOTS];
      int              height_of [SLOTS];
      int              top_idx;
      int              alloc_count;
      int              errors;
      int              n_checked;
      int              n_full;
      int              n_not_alloc;
      int              n_moves;
      int              n_hides;
      stack_reply_type replies [$];

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            stack_pos[i] = '0;
            in_use[i]    = 1'b0;
            height_of[i] = -1;
         end
         top_idx     = -1;
         alloc_count = 0;
         errors      = 0;
         n_checked   = 0;
         n_full      = 0;
         n_not_alloc = 0;
         n_moves     = 0;
         n_hides     = 0;
      endfunction

      function int pending();
         return replies.size();
      endfunction

      function void put_at(int pos, logic [7:0] id);
         stack_pos[pos] = id;
         height_of[id]  = pos;
      endfunction

      // Work out the reply to one accepted command and advance the stack.
      function void note_command(command_type cmd, logic [7:0] id, logic signed [9:0] req);
         stack_reply_type rep;
         int              slot;
         int              old_h;
         int              ceil_h;
         int              want;
         int              h;
         rep.status     = STATUS_OK;
         rep.layer      = id;
         rep.new_height = 9'(-1);
         rep.redraw     = 1'b0;
         if (cmd == CMD_ALLOC) begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!in_use[i] && slot < 0) slot = i;
            end
            if (slot >= 0) begin
               in_use[slot]    = 1'b1;
               height_of[slot] = -1;
               alloc_count++;
               rep.layer = 8'(slot);
            end else begin
               rep.status = STATUS_FULL;
               rep.layer  = '0;
               n_full++;
            end
         end else if (!in_use[id]) begin
            rep.status = STATUS_NOT_ALLOC;
            n_not_alloc++;
         end else begin
            old_h  = height_of[id];
            ceil_h = (old_h >= 0) ? top_idx : top_idx + 1;
            want   = req;
            if (want > ceil_h) want = ceil_h;
            if (want < -1) want = -1;
            if (old_h > want) begin
               if (want >= 0) begin
                  for (h = old_h; h > want; h--) put_at(h, stack_pos[h - 1]);
                  put_at(want, id);
               end else begin
                  for (h = old_h; h < top_idx; h++) put_at(h, stack_pos[h + 1]);
                  height_of[id] = -1;
                  top_idx--;
                  n_hides++;
               end
            end else if (old_h < want) begin
               if (old_h >= 0) begin
                  for (h = old_h; h < want; h++) put_at(h, stack_pos[h + 1]);
                  put_at(want, id);
               end else begin
                  for (h = top_idx; h >= want; h--) put_at(h + 1, stack_pos[h]);
                  put_at(want, id);
                  top_idx++;
               end
            end
            if (old_h != want) n_moves++;
            rep.new_height = 9'(height_of[id]);
            rep.redraw     = (old_h != want);
         end
         rep.top_height = 9'(top_idx);
         replies.push_back(rep);
      endfunction

      function void check_result(logic [1:0] status, logic [7:0] layer,
                                 logic signed [8:0] new_height,
                                 logic signed [8:0] top_height, logic redraw);
         stack_reply_type exp_r;
         if (replies.size() == 0) begin
            $error("result word with none expected: layer %0d", layer);
            errors++;
            return;
         end
         exp_r = replies.pop_front();
         n_checked++;
         if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            errors++;
         end
         if (layer !== exp_r.layer) begin
            $error("result_layer: expected %0d, got %0d", exp_r.layer, layer);
            errors++;
         end
         if (new_height !== exp_r.new_height) begin
            $error("new_height: expected %0d, got %0d", exp_r.new_height, new_height);
            errors++;
         end
         if (top_height !== exp_r.top_height) begin
            $error("top_height: expected %0d, got %0d", exp_r.top_height, top_height);
            errors++;
         end
         if (redraw !== exp_r.redraw) begin
            $error("redraw: expected %0d, got %0d", exp_r.redraw, redraw);
            errors++;
         end
      endfunction
   endclass

endpackage

### dv/window_layer_zorder_stack_tb.sv
`timescale 1ns / 1ps

module window_layer_zorder_stack_tb;
   import wlzs_pkg::*;
   import window_layer_zorder_stack_sb_pkg::*;

   localparam int RANDOM_WORDS = 1930;
   localparam int CALM_TAIL    = 200;        // final words sent back to back
   localparam int CYCLE_LIMIT  = 2_000_000;  // several times the slowest correct run

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              start        = 1'b0;
   logic              req_command  = 1'b0;
   logic [7:0]        req_layer_id = '0;
   logic signed [9:0] req_height   = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_result_layer;
   logic signed [8:0] rsp_new_height;
   logic signed [8:0] rsp_top_height;
   logic              rsp_redraw;

   layer_order_scoreboard sb;
   int                    cycle_count = 0;

   window_layer_zorder_stack u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_layer_id     (req_layer_id),
      .req_height       (req_height),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_layer (rsp_result_layer),
      .rsp_new_height   (rsp_new_height),
      .rsp_top_height   (rsp_top_height),
      .rsp_redraw       (rsp_redraw)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Capture every strobed result word on the edge that ends its cycle; the
   // block cannot be held off, so nothing else gates the check.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_status, rsp_result_layer, rsp_new_height,
                         rsp_top_height, rsp_redraw);
   end

   // Watchdog: give up if the stack never drains.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one command word at the falling edge and hold it until the block
   // takes it (start high, busy low at a rising edge). start stays high on
   // return, so a following word is presented without a gap.
   task automatic drive_word(input command_type cmd, input logic [7:0] id,
                             input logic signed [9:0] req);
      @(negedge clock);
      start        <= 1'b1;
      req_command  <= cmd;
      req_layer_id <= id;
      req_height   <= req;
      do @(posedge clock); while (busy);
      sb.note_command(cmd, id, req);
   endtask

   // Drop start for a short burst; optionally let the walk finish first so
   // the gap lands on the phase where the block is ready.
   task automatic idle_sender(input int cycles, input bit after_busy);
      @(negedge clock);
      start <= 1'b0;
      if (after_busy) begin
         do @(posedge clock); while (busy);
      end
      repeat (cycles) @(negedge clock);
   endtask

   // Drop start and hold off until every pending result word has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One random command. Most words are well-formed sets on claimed layers
   // with heights inside the legal span; the rest are allocates (which run
   // the pool dry eventually) and noise on arbitrary layer ids.
   task automatic random_word();
      int                pick;
      int                sub;
      logic [7:0]        id;
      logic signed [9:0] h;
      pick = $urandom_range(0, 99);
      id   = 8'($urandom);
      h    = 10'($urandom);
      if ((sb.alloc_count < SLOTS) ? (pick < 28) : (pick < 4)) begin
         drive_word(CMD_ALLOC, id, h);
      end else if (pick < 90 && sb.alloc_count > 0) begin
         // slots are claimed lowest first and never freed
         id  = 8'($urandom_range(0, sb.alloc_count - 1));
         sub = $urandom_range(0, 99);
         if (sub < 15)
            h = -10'sd1;
         else if (sub < 75)
            h = 10'($urandom_range(0, sb.top_idx + 1));
         else if (sub < 85)
            h = 10'(sb.height_of[id]);
         // otherwise keep the raw request so the clamp gets exercised
         drive_word(CMD_SET, id, h);
      end else begin
         drive_word(CMD_SET, id, h);
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: sets on unclaimed layers, a few allocates, then inserts,
      // moves up and down, hides, same-height requests and clamping at both
      // ends of the request range.
      drive_word(CMD_SET,   8'd0,   10'sd0);
      drive_word(CMD_SET,   8'd255, -10'sd512);
      drive_word(CMD_ALLOC, 8'd255, 10'sd511);
      drive_word(CMD_ALLOC, 8'd0,   -10'sd512);
      drive_word(CMD_ALLOC, 8'd170, 10'sd341);
      drive_word(CMD_ALLOC, 8'd85,  -10'sd342);
      drive_word(CMD_SET,   8'd0,   10'sd511);   // clamp to top+1 on an empty stack
      drive_word(CMD_SET,   8'd0,   10'sd0);     // same height, no redraw
      drive_word(CMD_SET,   8'd1,   -10'sd512);  // hidden stays hidden
      drive_word(CMD_SET,   8'd1,   10'sd0);     // insert at the bottom
      drive_word(CMD_SET,   8'd2,   10'sd511);   // insert on top
      drive_word(CMD_SET,   8'd3,   10'sd1);     // insert in the middle
      drive_word(CMD_SET,   8'd0,   10'sd511);   // visible: ceiling is top itself
      drive_word(CMD_SET,   8'd2,   10'sd0);     // move down to the bottom
      drive_word(CMD_SET,   8'd3,   -10'sd1);    // hide from the middle
      drive_word(CMD_SET,   8'd0,   -10'sd2);    // below -1 clamps: hide the top
      drive_word(CMD_SET,   8'd255, 10'sd5);
      drive_word(CMD_SET,   8'd4,   10'sd1);     // just past the claimed slots
      drive_word(CMD_ALLOC, 8'd0,   10'sd0);
      drive_word(CMD_SET,   8'd4,   -10'sd1);
      drive_word(CMD_SET,   8'd4,   10'sd1);
      drive_word(CMD_SET,   8'd1,   -10'sd1);
      hold_until_drained();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         random_word();
         if (n == RANDOM_WORDS / 2)
            hold_until_drained();
         else if (n < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 2) == 0)
            idle_sender($urandom_range(1, 3), 1'($urandom_range(0, 1)));
      end

      // Drain, then allow one more walk for anything stray.
      hold_until_drained();
      repeat (SLOTS + 8) @(posedge clock);

      $display("Layer stack run: %0d result words checked, %0d slots claimed, %0d allocates on a full pool",
               sb.n_checked, sb.alloc_count, sb.n_full);
      $display("  %0d height changes, %0d hides, %0d sets on unclaimed layers, final top %0d",
               sb.n_moves, sb.n_hides, sb.n_not_alloc, sb.top_idx);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### window_layer_zorder_stack.f
+incdir+hdl
hdl/wlzs_pkg.sv
hdl/wlzs_cell.sv
hdl/window_layer_zorder_stack.sv
dv/window_layer_zorder_stack_sb_pkg.sv
dv/window_layer_zorder_stack_tb.sv
